// ===== hdl/lav_pkg.sv =====
// Shared types and constants for the look-at view matrix block.
`timescale 1ns / 1ps
package lav_pkg;

  localparam int unsigned IN_DATA_W  = 288;
  localparam int unsigned OUT_DATA_W = 128;
  localparam int unsigned OUT_USER_W = 3;
  localparam logic signed [31:0] ONE_Q16 = 32'sd65536;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_ABS,
    OP_SHR,
    OP_SHL,
    OP_SQ,
    OP_SQRT_INIT,
    OP_SQRT,
    OP_DIV_INIT,
    OP_DIV,
    OP_DIV_WR,
    OP_CROSS_A,
    OP_CROSS_B,
    OP_KEEP,
    OP_DOT,
    OP_ROW
  } op_t;

  // Vector select: which unit vector a pass writes, or which row is built.
  localparam logic [1:0] SEL_F = 2'd0;
  localparam logic [1:0] SEL_R = 2'd1;
  localparam logic [1:0] SEL_U = 2'd2;
  localparam logic [1:0] ROW_LAST = 2'd3;

  typedef struct packed {
    op_t        op;
    logic [1:0] idx;
    logic [1:0] sel;
    logic       degen;
  } cmd_t;

  typedef struct packed {
    logic zero;
    logic hi;
    logic lo;
  } sts_t;

endpackage

// ===== hdl/lav_ctrl.sv =====
// Sequencer for the look-at view matrix block.
`timescale 1ns / 1ps
module lav_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  output logic          m_tvalid,
  input  logic          m_tready,
  input  lav_pkg::sts_t sts,
  output lav_pkg::cmd_t cmd
);
  import lav_pkg::*;

  typedef enum logic [14:0] {
    ST_IDLE      = 15'b000000000000001,
    ST_ABS       = 15'b000000000000010,
    ST_NORM      = 15'b000000000000100,
    ST_SQ        = 15'b000000000001000,
    ST_SQRT_INIT = 15'b000000000010000,
    ST_SQRT      = 15'b000000000100000,
    ST_DIV_INIT  = 15'b000000001000000,
    ST_DIV       = 15'b000000010000000,
    ST_DIV_WR    = 15'b000000100000000,
    ST_CROSS_A   = 15'b000001000000000,
    ST_CROSS_B   = 15'b000010000000000,
    ST_KEEP      = 15'b000100000000000,
    ST_DOT       = 15'b001000000000000,
    ST_ROW       = 15'b010000000000000,
    ST_WAIT      = 15'b100000000000000
  } state_t;

  state_t     state, state_next;
  logic [4:0] cnt, cnt_next;
  logic [1:0] idx, idx_next;
  logic [1:0] phase, phase_next;
  logic [1:0] row, row_next;
  logic       degen, degen_next;

  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = (state == ST_WAIT);

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    idx_next   = idx;
    phase_next = phase;
    row_next   = row;
    degen_next = degen;
    cmd.op     = OP_NONE;
    cmd.idx    = idx;
    cmd.sel    = phase;
    cmd.degen  = degen;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.op     = OP_LOAD;
          phase_next = SEL_F;
          degen_next = 1'b0;
          state_next = ST_ABS;
        end
      end
      ST_ABS: begin
        cmd.op     = OP_ABS;
        state_next = ST_NORM;
      end
      ST_NORM: begin
        if (sts.zero) begin
          degen_next = 1'b1;
          row_next   = 2'd0;
          state_next = ST_ROW;
        end else if (sts.hi) begin
          cmd.op = OP_SHR;
        end else if (sts.lo) begin
          cmd.op = OP_SHL;
        end else begin
          idx_next   = 2'd0;
          state_next = ST_SQ;
        end
      end
      ST_SQ: begin
        cmd.op   = OP_SQ;
        idx_next = idx + 2'd1;
        if (idx == 2'd2) begin
          state_next = ST_SQRT_INIT;
        end
      end
      ST_SQRT_INIT: begin
        cmd.op     = OP_SQRT_INIT;
        cnt_next   = '0;
        state_next = ST_SQRT;
      end
      ST_SQRT: begin
        cmd.op   = OP_SQRT;
        cnt_next = cnt + 5'd1;
        if (cnt == 5'd31) begin
          idx_next   = 2'd0;
          state_next = ST_DIV_INIT;
        end
      end
      ST_DIV_INIT: begin
        cmd.op     = OP_DIV_INIT;
        cnt_next   = '0;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        cmd.op   = OP_DIV;
        cnt_next = cnt + 5'd1;
        if (cnt == 5'd16) begin
          state_next = ST_DIV_WR;
        end
      end
      ST_DIV_WR: begin
        cmd.op = OP_DIV_WR;
        if (idx != 2'd2) begin
          idx_next   = idx + 2'd1;
          state_next = ST_DIV_INIT;
        end else if (phase == SEL_U) begin
          state_next = ST_KEEP;
        end else begin
          idx_next   = 2'd0;
          phase_next = phase + 2'd1;
          state_next = ST_CROSS_A;
        end
      end
      ST_CROSS_A: begin
        cmd.op     = OP_CROSS_A;
        state_next = ST_CROSS_B;
      end
      ST_CROSS_B: begin
        cmd.op   = OP_CROSS_B;
        idx_next = idx + 2'd1;
        state_next = (idx == 2'd2) ? ST_ABS : ST_CROSS_A;
      end
      ST_KEEP: begin
        cmd.op     = OP_KEEP;
        row_next   = 2'd0;
        idx_next   = 2'd0;
        state_next = ST_DOT;
      end
      ST_DOT: begin
        cmd.op   = OP_DOT;
        cmd.sel  = row;
        idx_next = idx + 2'd1;
        if (idx == 2'd2) begin
          state_next = ST_ROW;
        end
      end
      ST_ROW: begin
        cmd.op     = OP_ROW;
        cmd.sel    = row;
        state_next = ST_WAIT;
      end
      ST_WAIT: begin
        cmd.sel = row;
        if (m_tready) begin
          if (row == ROW_LAST) begin
            state_next = ST_IDLE;
          end else begin
            row_next   = row + 2'd1;
            idx_next   = 2'd0;
            state_next = (degen || row == 2'd2) ? ST_ROW : ST_DOT;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
      idx   <= '0;
      phase <= '0;
      row   <= '0;
      degen <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      idx   <= idx_next;
      phase <= phase_next;
      row   <= row_next;
      degen <= degen_next;
    end
  end

endmodule

// ===== hdl/lav_dp.sv =====
// Datapath: normalise, square root, divide, cross and dot products, row output.
`timescale 1ns / 1ps
module lav_dp (
  input  logic                             clk,
  input  logic                             rst,
  input  lav_pkg::cmd_t                    cmd,
  output lav_pkg::sts_t                    sts,
  input  logic [lav_pkg::IN_DATA_W-1:0]    in_data,
  input  logic                             in_take_up,
  output logic [lav_pkg::OUT_DATA_W-1:0]   out_data,
  output logic [lav_pkg::OUT_USER_W-1:0]   out_user,
  output logic                             out_last
);
  import lav_pkg::*;

  logic signed [31:0] pos  [3];
  logic signed [31:0] upv  [3];
  logic signed [31:0] kept [3];
  logic signed [50:0] vec  [3];
  logic        [50:0] mag  [3];
  logic               neg  [3];
  logic signed [17:0] fv   [3];
  logic signed [17:0] rv   [3];
  logic signed [17:0] uv   [3];
  logic        [63:0] acc;
  logic        [63:0] root;
  logic        [63:0] bitv;
  logic        [30:0] drem;
  logic        [16:0] dlow;
  logic        [16:0] quot;
  logic signed [50:0] prod;
  logic signed [31:0] col [4];
  logic        [1:0]  row_q;
  logic               degen_q;

  logic        [50:0] or_all;
  logic        [1:0]  j1, j2;
  logic signed [17:0] ca [3];
  logic signed [31:0] cb [3];
  logic signed [49:0] mul_a, mul_b, mul_d;
  logic signed [17:0] uk [3];
  logic        [59:0] sq;
  logic        [63:0] cand;
  logic        [30:0] len;
  logic        [46:0] num;
  logic        [31:0] dt;
  logic               dge;
  logic signed [17:0] unit_val;
  logic signed [63:0] xdot;
  logic        [63:0] xmag;
  logic        [47:0] q;
  logic signed [31:0] tsat;

  assign or_all   = mag[0] | mag[1] | mag[2];
  assign sts.zero = (or_all == '0);
  assign sts.hi   = |or_all[50:30];
  assign sts.lo   = ~|or_all[50:29];

  always_comb begin
    case (cmd.idx)
      2'd0:    begin j1 = 2'd1; j2 = 2'd2; end
      2'd1:    begin j1 = 2'd2; j2 = 2'd0; end
      default: begin j1 = 2'd0; j2 = 2'd1; end
    endcase
    for (int i = 0; i < 3; i++) begin
      ca[i] = (cmd.sel == SEL_U) ? rv[i] : fv[i];
      cb[i] = (cmd.sel == SEL_U) ? 32'(fv[i]) : upv[i];
      case (cmd.sel)
        SEL_F:   uk[i] = rv[i];
        SEL_R:   uk[i] = uv[i];
        default: uk[i] = fv[i];
      endcase
    end
    mul_a = ca[j1] * cb[j2];
    mul_b = ca[j2] * cb[j1];
    mul_d = uk[cmd.idx] * pos[cmd.idx];
    sq    = mag[cmd.idx][29:0] * mag[cmd.idx][29:0];
    cand  = root + bitv;
    len   = root[30:0];
    num   = {1'b0, mag[cmd.idx][29:0], 16'b0} + {17'b0, len[30:1]};
    dt    = {drem, dlow[16]};
    dge   = (dt >= {1'b0, len});
    unit_val = neg[cmd.idx] ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
    // Row 2 keeps the dot sign; rows 0 and 1 negate it.
    xdot  = (cmd.sel == SEL_U) ? $signed(acc) : -$signed(acc);
    xmag  = xdot[63] ? 64'(-xdot) : 64'(xdot);
    q     = 48'((xmag + 64'd32768) >> 16);
    if (!xdot[63]) begin
      tsat = (q > 48'h7FFFFFFF) ? 32'sh7FFFFFFF : $signed(q[31:0]);
    end else begin
      tsat = (q > 48'h80000000) ? 32'sh80000000 : -$signed(q[31:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      kept[0] <= '0;
      kept[1] <= ONE_Q16;
      kept[2] <= '0;
    end else if (cmd.op == OP_KEEP) begin
      for (int i = 0; i < 3; i++) kept[i] <= 32'(uv[i]);
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        for (int i = 0; i < 3; i++) begin
          pos[i] <= $signed(in_data[32*i +: 32]);
          vec[i] <= 51'($signed(in_data[96 + 32*i +: 32])) -
                    51'($signed(in_data[32*i +: 32]));
          upv[i] <= in_take_up ? $signed(in_data[192 + 32*i +: 32]) : kept[i];
        end
      end
      OP_ABS: begin
        for (int i = 0; i < 3; i++) begin
          neg[i] <= vec[i][50];
          mag[i] <= vec[i][50] ? 51'(-vec[i]) : 51'(vec[i]);
        end
      end
      OP_SHR: begin
        for (int i = 0; i < 3; i++) mag[i] <= mag[i] >> 1;
      end
      OP_SHL: begin
        for (int i = 0; i < 3; i++) mag[i] <= mag[i] << 1;
      end
      OP_SQ: begin
        acc <= ((cmd.idx == 2'd0) ? 64'd0 : acc) + {4'b0, sq};
      end
      OP_SQRT_INIT: begin
        root <= '0;
        bitv <= 64'd1 << 62;
      end
      OP_SQRT: begin
        if (acc >= cand) begin
          acc  <= acc - cand;
          root <= (root >> 1) + bitv;
        end else begin
          root <= root >> 1;
        end
        bitv <= bitv >> 2;
      end
      OP_DIV_INIT: begin
        drem <= {1'b0, num[46:17]};
        dlow <= num[16:0];
        quot <= '0;
      end
      OP_DIV: begin
        drem <= dge ? 31'(dt - {1'b0, len}) : dt[30:0];
        dlow <= dlow << 1;
        quot <= {quot[15:0], dge};
      end
      OP_DIV_WR: begin
        case (cmd.sel)
          SEL_F:   fv[cmd.idx] <= unit_val;
          SEL_R:   rv[cmd.idx] <= unit_val;
          default: uv[cmd.idx] <= unit_val;
        endcase
      end
      OP_CROSS_A: begin
        prod <= 51'(mul_a);
      end
      OP_CROSS_B: begin
        vec[cmd.idx] <= prod - 51'(mul_b);
      end
      OP_DOT: begin
        acc <= ((cmd.idx == 2'd0) ? 64'd0 : acc) + 64'(mul_d);
      end
      OP_ROW: begin
        row_q   <= cmd.sel;
        degen_q <= cmd.degen;
        if (cmd.degen || cmd.sel == ROW_LAST) begin
          for (int i = 0; i < 4; i++) begin
            col[i] <= (cmd.sel == 2'(i)) ? ONE_Q16 : 32'sd0;
          end
        end else begin
          for (int i = 0; i < 3; i++) begin
            case (cmd.sel)
              SEL_F:   col[i] <= 32'(rv[i]);
              SEL_R:   col[i] <= 32'(uv[i]);
              default: col[i] <= -32'(fv[i]);
            endcase
          end
          col[3] <= tsat;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_data = {col[3], col[2], col[1], col[0]};
  assign out_user = {degen_q, row_q};
  assign out_last = (row_q == ROW_LAST);

endmodule

// ===== hdl/look_at_view_matrix_top.sv =====
// Top level of the right-handed look-at view matrix block.
`timescale 1ns / 1ps
// Takes camera position, target and an optional up vector (Q16.16) and returns
// the view matrix as four row transactions, row 0 first, tlast on row 3. One
// camera is worked on at a time: s_tready is high only while idle. The time until
// an item's last row is offered is set by the three normalisations, each a
// bit-per-cycle magnitude shift, a 32-step square root and three 17-step
// divisions on one shared unit, and by output stalls. The orthonormal up is
// kept between items; a zero-length forward or right yields the identity with
// tuser degenerate set.
module look_at_view_matrix_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // pos_x, pos_y, pos_z, aim_x, aim_y, aim_z, new_up_x, new_up_y, new_up_z
  input  logic [lav_pkg::IN_DATA_W-1:0]       s_tdata,
  // take_new_up
  input  logic [0:0]                          s_tuser,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // col0, col1, col2, col3
  output logic [lav_pkg::OUT_DATA_W-1:0]      m_tdata,
  // row_number[1:0], degenerate[2]
  output logic [lav_pkg::OUT_USER_W-1:0]      m_tuser,
  output logic                                m_tlast
);
  import lav_pkg::*;

  cmd_t cmd;
  sts_t sts;

  lav_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lav_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .in_data    (s_tdata),
    .in_take_up (s_tuser[0]),
    .out_data   (m_tdata),
    .out_user   (m_tuser),
    .out_last   (m_tlast)
  );

  a_last_row: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tuser[1:0] == ROW_LAST)
    else $error("tlast on a row other than the last");

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("input taken while a row is pending");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && m_tlast |=> s_tready)
    else $error("not idle after the final row");

endmodule

// ===== test/look_at_view_matrix_top_tb.sv =====
// Self-checking testbench for the look-at view matrix block.
`timescale 1ns / 1ps
module look_at_view_matrix_top_tb;
  import lav_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 20000;
  localparam int unsigned LONG_HOLD = 3000;
  localparam int unsigned N_RANDOM = 380;

  typedef struct {
    longint x;
    longint y;
    longint z;
  } vec3_t;

  typedef struct {
    logic [1:0]  row;
    logic [31:0] c0;
    logic [31:0] c1;
    logic [31:0] c2;
    logic [31:0] c3;
    logic        degen;
    logic        last;
  } view_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic [0:0]            s_tuser = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [OUT_USER_W-1:0] m_tuser;
  logic                  m_tlast;

  view_row_t row_queue[$];
  vec3_t     up_model;
  int        mismatches = 0;
  int        cameras_sent = 0;
  int        rows_seen = 0;
  int        degen_sent = 0;
  int        burst_left = 0;
  int        idle_cycles = 0;
  bit        hold_request = 1'b0;
  bit        hold_active = 1'b0;

  always #5 clk = ~clk;

  look_at_view_matrix_top dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned rem;
    longint unsigned root;
    longint unsigned bitv;
    rem = v;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > rem) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (rem >= root + bitv) begin
        rem = rem - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  // Scale the group so the largest magnitude sits in [2^29, 2^30), then divide by length.
  function automatic bit unit_vec(input vec3_t v, output vec3_t u);
    longint          comp[3];
    longint unsigned mag[3];
    bit              neg[3];
    longint unsigned mx;
    longint unsigned sum;
    longint unsigned len;
    longint          q[3];
    comp[0] = v.x;
    comp[1] = v.y;
    comp[2] = v.z;
    mx = 0;
    sum = 0;
    u = '{0, 0, 0};
    for (int i = 0; i < 3; i++) begin
      neg[i] = comp[i] < 0;
      mag[i] = neg[i] ? longint'(-comp[i]) : longint'(comp[i]);
      if (mag[i] > mx) mx = mag[i];
    end
    if (mx == 0) return 1'b0;
    while (mx >= (64'd1 << 30)) begin
      for (int i = 0; i < 3; i++) mag[i] = mag[i] >> 1;
      mx = mx >> 1;
    end
    while (mx < (64'd1 << 29)) begin
      for (int i = 0; i < 3; i++) mag[i] = mag[i] << 1;
      mx = mx << 1;
    end
    for (int i = 0; i < 3; i++) sum = sum + mag[i] * mag[i];
    len = int_sqrt(sum);
    if (len == 0) return 1'b0;
    for (int i = 0; i < 3; i++) begin
      q[i] = longint'((mag[i] * 64'd65536 + len / 2) / len);
      if (neg[i]) q[i] = -q[i];
    end
    u = '{q[0], q[1], q[2]};
    return 1'b1;
  endfunction

  function automatic vec3_t cross_of(input vec3_t a, input vec3_t b);
    vec3_t c;
    c.x = a.y * b.z - a.z * b.y;
    c.y = a.z * b.x - a.x * b.z;
    c.z = a.x * b.y - a.y * b.x;
    return c;
  endfunction

  function automatic longint dot_of(input vec3_t a, input vec3_t b);
    return a.x * b.x + a.y * b.y + a.z * b.z;
  endfunction

  // Q32.32 to Q16.16, half away from zero, clamp to 32 bits.
  function automatic logic [31:0] round_clamp(input longint x);
    longint unsigned mag;
    longint          q;
    mag = (x < 0) ? longint'(-x) : longint'(x);
    q = longint'((mag + 64'd32768) >> 16);
    if (x < 0) q = -q;
    if (q > 64'sd2147483647) q = 64'sd2147483647;
    if (q < -64'sd2147483648) q = -64'sd2147483648;
    return q[31:0];
  endfunction

  task automatic push_row(input int r, input longint a, input longint b, input longint c,
                          input logic [31:0] t, input bit dg);
    view_row_t e;
    e.row = r[1:0];
    e.c0 = a[31:0];
    e.c1 = b[31:0];
    e.c2 = c[31:0];
    e.c3 = t;
    e.degen = dg;
    e.last = (r == 3);
    row_queue.push_back(e);
  endtask

  task automatic predict_view(input vec3_t pos, input vec3_t aim, input vec3_t up_in,
                              input bit take);
    vec3_t d;
    vec3_t f;
    vec3_t r;
    vec3_t u;
    vec3_t up_used;
    bit    ok;
    d = '{aim.x - pos.x, aim.y - pos.y, aim.z - pos.z};
    up_used = take ? up_in : up_model;
    ok = unit_vec(d, f);
    if (ok) ok = unit_vec(cross_of(f, up_used), r);
    if (ok) ok = unit_vec(cross_of(r, f), u);
    if (!ok) begin
      degen_sent++;
      push_row(0, 65536, 0, 0, 32'd0, 1'b1);
      push_row(1, 0, 65536, 0, 32'd0, 1'b1);
      push_row(2, 0, 0, 65536, 32'd0, 1'b1);
      push_row(3, 0, 0, 0, 32'd65536, 1'b1);
    end else begin
      up_model = u;
      push_row(0, r.x, r.y, r.z, round_clamp(-dot_of(r, pos)), 1'b0);
      push_row(1, u.x, u.y, u.z, round_clamp(-dot_of(u, pos)), 1'b0);
      push_row(2, -f.x, -f.y, -f.z, round_clamp(dot_of(f, pos)), 1'b0);
      push_row(3, 0, 0, 0, 32'd65536, 1'b0);
    end
  endtask

  function automatic vec3_t mk(input logic [31:0] a, input logic [31:0] b,
                               input logic [31:0] c);
    vec3_t v;
    v.x = longint'(signed'(a));
    v.y = longint'(signed'(b));
    v.z = longint'(signed'(c));
    return v;
  endfunction

  // Hold valid across back-to-back transactions; drop it only for a gap.
  task automatic send_camera(input vec3_t pos, input vec3_t aim, input vec3_t up_in,
                             input bit take);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 8);
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 450) : $urandom_range(0, 4);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tdata <= {up_in.z[31:0], up_in.y[31:0], up_in.x[31:0], aim.z[31:0], aim.y[31:0],
                aim.x[31:0], pos.z[31:0], pos.y[31:0], pos.x[31:0]};
    s_tuser <= take;
    s_tvalid <= 1'b1;
    do @(negedge clk); while (!s_tready);
    @(posedge clk);
    predict_view(pos, aim, up_in, take);
    cameras_sent++;
  endtask

  task automatic drain_rows;
    s_tvalid <= 1'b0;
    while (row_queue.size() != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0, 1: return $urandom;
      2: return 32'($urandom_range(0, 2097152)) - 32'd1048576;
      3: return 32'($urandom_range(0, 256)) - 32'd128;
      4: return {$urandom_range(0, 1) ? 16'hffff : 16'h0000, 16'($urandom)};
      default: return 32'($urandom_range(0, 20)) << 16;
    endcase
  endfunction

  function automatic vec3_t rand_vec();
    return mk(rand_coord(), rand_coord(), rand_coord());
  endfunction

  task automatic test_directed;
    vec3_t o;
    o = mk(0, 0, 0);
    send_camera(o, mk(0, 0, -32'sd65536), o, 1'b0);
    send_camera(mk(32'd65536, 32'd131072, 0), mk(0, 0, 0), o, 1'b0);
    // zero-length forward
    send_camera(mk(32'd12345, -32'sd99, 32'd7), mk(32'd12345, -32'sd99, 32'd7), o, 1'b0);
    // forward along the y axis
    send_camera(o, mk(0, 32'd65536 * 5, 0), o, 1'b0);
    // supplied zero up, also discarded on degeneracy
    send_camera(o, mk(32'd65536, 0, 0), o, 1'b1);
    send_camera(o, o, mk(32'd65536, 0, 0), 1'b1);
    send_camera(o, mk(0, 0, 32'd65536), mk(0, 0, 32'd65536), 1'b1);
    // extreme corners, huge differences
    send_camera(mk(32'h80000000, 32'h80000000, 32'h80000000),
                mk(32'h7fffffff, 32'h7fffffff, 32'h7fffffff), mk(0, 32'h7fffffff, 0), 1'b1);
    send_camera(mk(32'h7fffffff, 32'h7fffffff, 32'h7fffffff),
                mk(32'h80000000, 32'h80000000, 32'h80000000), mk(32'h80000000, 0, 0), 1'b1);
    // full-scale translation along one axis
    send_camera(mk(32'h7fffffff, 0, 0), mk(32'h80000000, 0, 0), mk(0, 32'd65536, 0), 1'b1);
    send_camera(mk(32'h80000000, 0, 0), mk(32'h7fffffff, 0, 0), mk(0, 0, 32'h80000000), 1'b1);
    send_camera(mk(0, 32'h80000000, 0), mk(0, 32'h7fffffff, 1), mk(32'hffffffff, 0, 0), 1'b1);
    // smallest nonzero differences and ups
    send_camera(o, mk(1, 0, 0), mk(0, 1, 0), 1'b1);
    send_camera(o, mk(32'hffffffff, 32'hffffffff, 1), mk(1, 32'hffffffff, 0), 1'b1);
    send_camera(mk(32'hffffffff, 32'hffffffff, 32'hffffffff), mk(32'h55555555, 32'haaaaaaaa,
                32'h12345678), mk(32'haaaaaaaa, 32'h55555555, 32'hedcba987), 1'b1);
    send_camera(mk(32'h0000ffff, 32'hffff0000, 32'h00010000), mk(32'h40000000, 32'hc0000000, 0),
                mk(32'h7fffffff, 32'h7fffffff, 32'h80000000), 1'b0);
    send_camera(rand_vec(), rand_vec(), rand_vec(), 1'b0);
    drain_rows();
  endtask

  task automatic test_random;
    vec3_t p;
    for (int n = 0; n < N_RANDOM; n++) begin
      p = rand_vec();
      if ($urandom_range(0, 19) == 0) send_camera(p, p, rand_vec(), $urandom_range(0, 1));
      else send_camera(p, rand_vec(), rand_vec(), $urandom_range(0, 1));
    end
  endtask

  // Receiver holds off while the sender keeps offering cameras.
  task automatic test_backpressure;
    hold_request = 1'b1;
    wait (hold_active);
    hold_request = 1'b0;
    for (int n = 0; n < 4; n++) send_camera(rand_vec(), rand_vec(), rand_vec(), 1'b1);
    drain_rows();
  endtask

  task automatic test_pause_for_drain;
    send_camera(rand_vec(), rand_vec(), rand_vec(), 1'b0);
    drain_rows();
    send_camera(rand_vec(), rand_vec(), rand_vec(), 1'b0);
    drain_rows();
  endtask

  // Receiver stall pattern: a long hold on request, else always ready, coin toss, or mostly stalled.
  always @(posedge clk) begin : receiver
    int hold_cnt;
    int pat_left;
    int mode;
    if (hold_request && hold_cnt == 0) hold_cnt = LONG_HOLD;
    if (hold_cnt > 0) begin
      hold_cnt--;
      hold_active <= 1'b1;
      m_tready <= 1'b0;
    end else begin
      hold_active <= 1'b0;
      if (pat_left <= 0) begin
        pat_left = $urandom_range(1, 200);
        mode = $urandom_range(0, 2);
      end
      pat_left--;
      case (mode)
        0: m_tready <= 1'b1;
        1: m_tready <= $urandom_range(0, 1);
        default: m_tready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // Sample mid-cycle; values hold until the edge that completes the transaction.
  always @(negedge clk) begin : row_check
    view_row_t e;
    bit        bad;
    if (!rst && m_tvalid && m_tready) begin
      rows_seen++;
      if (row_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected row transaction tdata=%h tuser=%b", m_tdata,
                                       m_tuser);
      end else begin
        e = row_queue.pop_front();
        bad = (m_tuser[1:0] !== e.row) || (m_tdata[31:0] !== e.c0) ||
              (m_tdata[63:32] !== e.c1) || (m_tdata[95:64] !== e.c2) ||
              (m_tdata[127:96] !== e.c3) || (m_tuser[2] !== e.degen) || (m_tlast !== e.last);
        if (bad) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("row mismatch: exp row=%0d cols=%h %h %h %h degen=%b last=%b;",
                     e.row, e.c0, e.c1, e.c2, e.c3, e.degen, e.last);
            $display("              got row=%0d cols=%h %h %h %h degen=%b last=%b",
                     m_tuser[1:0], m_tdata[31:0], m_tdata[63:32], m_tdata[95:64],
                     m_tdata[127:96], m_tuser[2], m_tlast);
          end
        end
      end
    end
  end

  always @(negedge clk) begin : watchdog
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no transaction for %0d cycles, %0d rows pending", idle_cycles,
               row_queue.size());
      $display("look_at_view_matrix_top verification failed");
      $finish;
    end
  end

  initial begin
    up_model = mk(0, 32'd65536, 0);
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_pause_for_drain();
    test_random();
    drain_rows();
    repeat (50) @(posedge clk);
    $display("sent %0d cameras (%0d degenerate), checked %0d rows", cameras_sent, degen_sent,
             rows_seen);
    $display("covered edge values, degenerate inputs, a long output hold and random bursts");
    if (mismatches == 0 && row_queue.size() == 0) begin
      $display("look_at_view_matrix_top verification clean");
    end else begin
      $display("%0d mismatches, %0d rows still expected", mismatches, row_queue.size());
      $display("look_at_view_matrix_top verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/lav_pkg.sv
hdl/lav_ctrl.sv
hdl/lav_dp.sv
hdl/look_at_view_matrix_top.sv
test/look_at_view_matrix_top_tb.sv
